[hw/rtl/smdb_pkg.sv]
// ----------------------------------------------------------------------------
// Density binner package
// Types, codes and fixed constants shared by the density binner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package smdb_pkg;

  localparam int NTONES     = 20;
  localparam int NTHRES     = 10;
  localparam int QUO_W      = 16;
  localparam int STRIDE_W   = 17;
  localparam int IDX_W      = 16;
  localparam int VAL_W      = 32;
  localparam int CODE_W     = 6;
  localparam int CHAR_W     = 7;
  localparam int SIDE_W     = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAXW_W     = 6;
  localparam int STEP_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS, REG_COLS, REG_MAXW, REG_STRIDE, REG_STRUCT
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD, MODE_READ, MODE_CLEAR, MODE_NOP
  } mode_t;

  typedef enum logic [2:0] {
    JOB_STRIDE, JOB_GW, JOB_GH, JOB_ROW, JOB_COL, JOB_TEN
  } div_job_t;

  typedef enum logic {
    DIV_QUO, DIV_TEN
  } div_op_t;

  typedef enum logic [1:0] {
    RES_OK, RES_DROP, RES_CODE
  } res_kind_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_PREP, ST_STR_WAIT, ST_GW_START, ST_GW_WAIT,
    ST_GH_START, ST_GH_WAIT, ST_DISPATCH, ST_ROW_WAIT, ST_COL_START,
    ST_COL_WAIT, ST_CHECK, ST_MEM_RD, ST_LATCH, ST_ADD_WR, ST_DECIDE,
    ST_TEN_WAIT, ST_CLEAR, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic      capture;
    logic      stride_direct;
    logic      div_start;
    div_job_t  job;
    logic      dirty_clr;
    logic      bin_direct;
    logic      mem_rd;
    logic      x_load;
    logic      add_wr;
    logic      clr_max;
    logic      clr_step;
    logic      res_load;
    res_kind_t res_kind;
  } smdb_cmd_t;

  typedef struct packed {
    logic  dirty;
    logic  mw_zero;
    logic  div_done;
    logic  out_of_grid;
    logic  need_ten;
    logic  clr_last;
    logic  out_full;
    mode_t mode;
  } smdb_sts_t;

  // Character of a palette code in the alphabet 0-9 A-Z a-z + /.
  function automatic logic [CHAR_W-1:0] char_of(input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] r;
    if (c < 6'd10) begin
      r = 7'd48 + CHAR_W'(c);
    end else if (c < 6'd36) begin
      r = 7'd55 + CHAR_W'(c);
    end else if (c < 6'd62) begin
      r = 7'd61 + CHAR_W'(c);
    end else if (c == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/smdb_if.sv]
// ----------------------------------------------------------------------------
// Density binner channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface smdb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] row_index;
  logic [15:0] col_index;
  logic signed [31:0] entry_value;
  modport source (output valid, mode, row_index, col_index, entry_value, input ready);
  modport sink (input valid, mode, row_index, col_index, entry_value, output ready);
endinterface

interface smdb_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] palette_index;
  logic [6:0] pixel_char;
  logic       status;
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  modport source (output valid, palette_index, pixel_char, status, grid_width,
                  grid_height, input ready);
  modport sink (input valid, palette_index, pixel_char, status, grid_width,
                grid_height, output ready);
endinterface

interface smdb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sparse_matrix_density_binner_top.sv]
// ----------------------------------------------------------------------------
// Sparse matrix density binner
// Bins matrix entries into a downsampled grid and returns palette codes.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_ch    sink       mode, row_index, col_index, entry_value
// out_ch   source     palette_index, pixel_char, status, grid_width, grid_height
// cfg_ch   sink       index, data (always ready)
//
// One item at a time, one result per item. An add makes two 16-step divisions
// by the stride in the shared divider, a read up to ten tenths steps, a clear
// a sweep of all GRID_SIDE*GRID_SIDE store words. The first item after a
// register write first works out the stride and grid sides again. After reset
// a sweep of all GRID_SIDE*GRID_SIDE words zeroes the store before input is
// taken. A stalled result stays in the output register while the next
// transaction is already accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sparse_matrix_density_binner_top #(
  parameter int GRID_SIDE = 64,
  parameter int SUM_WIDTH = 48
) (
  input wire logic  clk,
  input wire logic  rst_n,
  smdb_in_if.sink   in_ch,
  smdb_out_if.source out_ch,
  smdb_cfg_if.sink  cfg_ch
);
  import smdb_pkg::*;

  smdb_cmd_t cmd;
  smdb_sts_t sts;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  smdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smdb_datapath #(.GRID_SIDE(GRID_SIDE), .SUM_WIDTH(SUM_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_ch.mode),
    .in_row      (in_ch.row_index),
    .in_col      (in_ch.col_index),
    .in_value    (in_ch.entry_value),
    .cfg_valid   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_palette (out_ch.palette_index),
    .out_char    (out_ch.pixel_char),
    .out_status  (out_ch.status),
    .out_gw      (out_ch.grid_width),
    .out_gh      (out_ch.grid_height)
  );
endmodule
`default_nettype wire

[hw/rtl/smdb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smdb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

[hw/rtl/smdb_div.sv]
// ----------------------------------------------------------------------------
// Shared iterative divider
// Restoring 16-bit quotient division, or the ten-step tenths quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smdb_div #(
  parameter int SUM_WIDTH = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire smdb_pkg::div_op_t            op,
  input  wire logic [SUM_WIDTH-1:0]         num,
  input  wire logic [SUM_WIDTH-1:0]         den,
  output logic                              busy,
  output logic                              done,
  output logic [smdb_pkg::QUO_W-1:0]        quo
);
  import smdb_pkg::*;

  logic                   busy_r, done_r;
  div_op_t                op_r;
  logic [STEP_W-1:0]      cnt_r;
  logic [SUM_WIDTH:0]     rem_r;
  logic [SUM_WIDTH-1:0]   num_r, den_r;
  logic [QUO_W-1:0]       q_r;
  logic [SUM_WIDTH:0]     trial, rem_step;
  logic                   ge, last;

  // Division shifts in one numerator bit a step; tenths adds the numerator.
  assign trial = (op_r == DIV_TEN) ? rem_r + {1'b0, num_r}
                                   : {rem_r[SUM_WIDTH-1:0], num_r[QUO_W-1]};
  assign ge       = trial >= {1'b0, den_r};
  assign rem_step = ge ? trial - {1'b0, den_r} : trial;
  assign last     = (op_r == DIV_TEN) ? (cnt_r == STEP_W'(NTHRES - 1))
                                      : (cnt_r == STEP_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_step;
      if (op_r == DIV_TEN) begin
        q_r <= q_r + QUO_W'(ge);
      end else begin
        q_r   <= {q_r[QUO_W-2:0], ge};
        num_r <= {num_r[SUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

[hw/rtl/smdb_datapath.sv]
// ----------------------------------------------------------------------------
// Density binner datapath
// Configuration, grid geometry, bin store, accumulation and palette coding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smdb_datapath #(
  parameter int GRID_SIDE = 64,
  parameter int SUM_WIDTH = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire smdb_pkg::smdb_cmd_t              cmd,
  output smdb_pkg::smdb_sts_t                   sts,
  input  wire logic [smdb_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [smdb_pkg::IDX_W-1:0]       in_row,
  input  wire logic [smdb_pkg::IDX_W-1:0]       in_col,
  input  wire logic signed [smdb_pkg::VAL_W-1:0] in_value,
  input  wire logic                             cfg_valid,
  input  wire logic [smdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smdb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [smdb_pkg::CODE_W-1:0]           out_palette,
  output logic [smdb_pkg::CHAR_W-1:0]           out_char,
  output logic                                  out_status,
  output logic [smdb_pkg::SIDE_W-1:0]           out_gw,
  output logic [smdb_pkg::SIDE_W-1:0]           out_gh
);
  import smdb_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int GSW   = $clog2(GRID_SIDE + 1);

  // Configuration and derived geometry
  logic [IDX_W-1:0]      rows_r, cols_r, stride_set_r;
  logic [MAXW_W-1:0]     maxw_r;
  logic                  struct_r, dirty_r;
  logic [STRIDE_W-1:0]   stride_r;
  logic [GSW-1:0]        gw_r, gh_r;

  // Item and working values
  mode_t                 mode_r;
  logic [IDX_W-1:0]      r_r, c_r, br_r, bc_r;
  logic signed [VAL_W-1:0] v_r;
  logic signed [SUM_WIDTH-1:0] x_r, max_r;
  logic [QUO_W-1:0]      tq_r;
  div_job_t              job_r;
  logic [AW-1:0]         clr_cnt_r;

  // Result register
  logic                  out_valid_r, status_r;
  logic [CODE_W-1:0]     pal_r;
  logic [GSW-1:0]        gw_out_r, gh_out_r;

  logic [SUM_WIDTH-1:0]  div_num, div_den, mag, rdata;
  logic                  div_busy, div_done;
  logic [QUO_W-1:0]      div_quo;
  logic [STRIDE_W-1:0]   q_plus;
  logic [GSW-1:0]        side_clamped;
  logic [AW-1:0]         bin_addr, waddr;
  logic [SUM_WIDTH:0]    sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic                  need_ten, ram_we;
  logic [CODE_W-1:0]     t6, code_pos, code_neg, code;

  always_comb begin
    case (cmd.job)
      JOB_STRIDE: begin
        div_num = SUM_WIDTH'(cols_r);
        div_den = SUM_WIDTH'(maxw_r);
      end
      JOB_GW: begin
        div_num = SUM_WIDTH'(cols_r);
        div_den = SUM_WIDTH'(stride_r);
      end
      JOB_GH: begin
        div_num = SUM_WIDTH'(rows_r);
        div_den = SUM_WIDTH'(stride_r);
      end
      JOB_ROW: begin
        div_num = SUM_WIDTH'(r_r);
        div_den = SUM_WIDTH'(stride_r);
      end
      JOB_COL: begin
        div_num = SUM_WIDTH'(c_r);
        div_den = SUM_WIDTH'(stride_r);
      end
      JOB_TEN: begin
        div_num = mag;
        div_den = max_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  smdb_div #(.SUM_WIDTH(SUM_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .op    ((cmd.job == JOB_TEN) ? DIV_TEN : DIV_QUO),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // A grid side is the quotient plus one, clamped to the store's side.
  assign q_plus       = {1'b0, div_quo} + STRIDE_W'(1);
  assign side_clamped = (q_plus > STRIDE_W'(GRID_SIDE)) ? GSW'(GRID_SIDE) : GSW'(q_plus);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= IDX_W'(1);
      cols_r       <= IDX_W'(1);
      maxw_r       <= '0;
      stride_set_r <= IDX_W'(1);
      struct_r     <= 1'b0;
      dirty_r      <= 1'b1;
      stride_r     <= STRIDE_W'(1);
      gw_r         <= GSW'(2);
      gh_r         <= GSW'(2);
      job_r        <= JOB_STRIDE;
    end else begin
      if (cfg_valid) begin
        dirty_r <= 1'b1;
        case (cfg_reg_t'(cfg_index))
          REG_ROWS:   rows_r       <= cfg_data;
          REG_COLS:   cols_r       <= cfg_data;
          REG_MAXW:   maxw_r       <= cfg_data[MAXW_W-1:0];
          REG_STRIDE: stride_set_r <= cfg_data;
          REG_STRUCT: struct_r     <= cfg_data[0];
          default:    ;
        endcase
      end else if (cmd.dirty_clr) begin
        dirty_r <= 1'b0;
      end
      if (cmd.div_start) begin
        job_r <= cmd.job;
      end
      if (cmd.stride_direct) begin
        stride_r <= (stride_set_r == '0) ? STRIDE_W'(1) : {1'b0, stride_set_r};
      end
      if (div_done) begin
        case (job_r)
          JOB_STRIDE: stride_r <= q_plus;
          JOB_GW:     gw_r     <= side_clamped;
          JOB_GH:     gh_r     <= side_clamped;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      r_r    <= in_row;
      c_r    <= in_col;
      v_r    <= in_value;
    end
    if (cmd.bin_direct) begin
      br_r <= r_r;
      bc_r <= c_r;
    end
    if (div_done) begin
      case (job_r)
        JOB_ROW: br_r <= div_quo;
        JOB_COL: bc_r <= div_quo;
        JOB_TEN: tq_r <= div_quo;
        default: ;
      endcase
    end
    if (cmd.x_load) begin
      x_r <= rdata;
    end
  end

  // Bin store, swept to zero after reset and on every clear item.
  assign bin_addr = AW'(32'(br_r) * 32'(GRID_SIDE) + 32'(bc_r));
  assign ram_we   = cmd.add_wr | cmd.clr_step;
  assign waddr    = cmd.clr_step ? clr_cnt_r : bin_addr;

  smdb_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (cmd.clr_step ? '0 : sum_sat),
    .re    (cmd.mem_rd),
    .raddr (bin_addr),
    .rdata (rdata)
  );

  // Saturating accumulate: an overflow shows as disagreeing top two bits.
  assign sum_ext = {x_r[SUM_WIDTH-1], x_r} + (SUM_WIDTH+1)'(v_r);
  always_comb begin
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_max) begin
        max_r <= '0;
      end else if (cmd.add_wr && (sum_sat > max_r)) begin
        max_r <= sum_sat;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= (clr_cnt_r == AW'(DEPTH - 1)) ? '0 : clr_cnt_r + 1'b1;
      end
    end
  end

  // Palette code. The running maximum never goes below zero.
  assign mag      = x_r[SUM_WIDTH-1] ? (~x_r + 1'b1) : x_r;
  assign need_ten = !struct_r && (x_r != '0) && (max_r != '0) && (mag < max_r);
  assign t6       = need_ten ? CODE_W'(tq_r) : CODE_W'(NTHRES);
  assign code_pos = ((6'd11 + t6) > CODE_W'(NTONES)) ? CODE_W'(NTONES) : 6'd11 + t6;
  assign code_neg = ((6'd31 + t6) > CODE_W'(2 * NTONES)) ? CODE_W'(2 * NTONES) : 6'd31 + t6;

  always_comb begin
    if (x_r == '0) begin
      code = '0;
    end else if (struct_r) begin
      code = x_r[SUM_WIDTH-1] ? CODE_W'(2 * NTONES) : CODE_W'(NTONES);
    end else begin
      code = x_r[SUM_WIDTH-1] ? code_neg : code_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pal_r    <= (cmd.res_kind == RES_CODE) ? code : '0;
      status_r <= (cmd.res_kind == RES_DROP);
      gw_out_r <= gw_r;
      gh_out_r <= gh_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_palette = pal_r;
  assign out_char    = char_of(pal_r);
  assign out_status  = status_r;
  assign out_gw      = SIDE_W'(gw_out_r);
  assign out_gh      = SIDE_W'(gh_out_r);

  always_comb begin
    sts             = '0;
    sts.dirty       = dirty_r;
    sts.mw_zero     = (maxw_r == '0);
    sts.div_done    = div_done;
    sts.out_of_grid = (br_r >= IDX_W'(gh_r)) || (bc_r >= IDX_W'(gw_r));
    sts.need_ten    = need_ten;
    sts.clr_last    = (clr_cnt_r == AW'(DEPTH - 1));
    sts.out_full    = out_valid_r && !out_ready;
    sts.mode        = mode_r;
  end

  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !max_r[SUM_WIDTH-1]) else $error("running maximum went negative");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy) else $error("divider started while busy");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r) else $error("result load lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before transfer");
endmodule
`default_nettype wire

[hw/rtl/smdb_ctrl.sv]
// ----------------------------------------------------------------------------
// Density binner controller
// Sequences geometry updates, divisions, bin store access and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smdb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire smdb_pkg::smdb_sts_t  sts,
  output smdb_pkg::smdb_cmd_t       cmd
);
  import smdb_pkg::*;

  ctrl_state_t state_r, state_nxt;
  res_kind_t   res_kind_r, res_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      res_kind_r <= RES_OK;
    end else begin
      state_r    <= state_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    res_kind_nxt = res_kind_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      // After a register write the stride and grid sides are worked out again.
      ST_PREP: begin
        if (!sts.dirty) begin
          state_nxt = ST_DISPATCH;
        end else if (sts.mw_zero) begin
          cmd.stride_direct = 1'b1;
          state_nxt         = ST_GW_START;
        end else begin
          cmd.div_start = 1'b1;
          cmd.job       = JOB_STRIDE;
          state_nxt     = ST_STR_WAIT;
        end
      end
      ST_STR_WAIT: if (sts.div_done) state_nxt = ST_GW_START;
      ST_GW_START: begin
        cmd.div_start = 1'b1;
        cmd.job       = JOB_GW;
        state_nxt     = ST_GW_WAIT;
      end
      ST_GW_WAIT: if (sts.div_done) state_nxt = ST_GH_START;
      ST_GH_START: begin
        cmd.div_start = 1'b1;
        cmd.job       = JOB_GH;
        state_nxt     = ST_GH_WAIT;
      end
      ST_GH_WAIT: begin
        if (sts.div_done) begin
          cmd.dirty_clr = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.mode)
          MODE_ADD: begin
            cmd.div_start = 1'b1;
            cmd.job       = JOB_ROW;
            state_nxt     = ST_ROW_WAIT;
          end
          MODE_READ: begin
            cmd.bin_direct = 1'b1;
            state_nxt      = ST_CHECK;
          end
          MODE_CLEAR: begin
            cmd.clr_max = 1'b1;
            state_nxt   = ST_CLEAR;
          end
          default: begin
            res_kind_nxt = RES_OK;
            state_nxt    = ST_OUT;
          end
        endcase
      end
      ST_ROW_WAIT: if (sts.div_done) state_nxt = ST_COL_START;
      ST_COL_START: begin
        cmd.div_start = 1'b1;
        cmd.job       = JOB_COL;
        state_nxt     = ST_COL_WAIT;
      end
      ST_COL_WAIT: if (sts.div_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.out_of_grid) begin
          res_kind_nxt = RES_DROP;
          state_nxt    = ST_OUT;
        end else begin
          state_nxt = ST_MEM_RD;
        end
      end
      ST_MEM_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.x_load = 1'b1;
        state_nxt  = (sts.mode == MODE_ADD) ? ST_ADD_WR : ST_DECIDE;
      end
      ST_ADD_WR: begin
        cmd.add_wr   = 1'b1;
        res_kind_nxt = RES_OK;
        state_nxt    = ST_OUT;
      end
      ST_DECIDE: begin
        if (sts.need_ten) begin
          cmd.div_start = 1'b1;
          cmd.job       = JOB_TEN;
          state_nxt     = ST_TEN_WAIT;
        end else begin
          res_kind_nxt = RES_CODE;
          state_nxt    = ST_OUT;
        end
      end
      ST_TEN_WAIT: begin
        if (sts.div_done) begin
          res_kind_nxt = RES_CODE;
          state_nxt    = ST_OUT;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          res_kind_nxt = RES_OK;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts.out_full) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = res_kind_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[verif/sparse_matrix_density_binner_top_tb.sv]
// ----------------------------------------------------------------------------
// Density binner testbench
// Drives add, read, clear and no-op transactions through the binner under
// several register settings, predicts every result from a behavioural copy
// of the bin store and checks each returned transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sparse_matrix_density_binner_top_tb;
  import smdb_pkg::*;

  localparam int SIDE = 64;
  localparam int SUMW = 48;
  localparam longint LIMIT = 3_000_000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] value;
  } bin_req_t;

  typedef struct packed {
    logic [5:0] code;
    logic [6:0] chr;
    logic       status;
    logic [6:0] gw;
    logic [6:0] gh;
  } bin_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smdb_in_if  in_ch ();
  smdb_out_if out_ch ();
  smdb_cfg_if cfg_ch ();

  sparse_matrix_density_binner_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [15:0] p_rows, p_cols, p_stride_set;
  logic [5:0]  p_maxw;
  logic        p_struct;
  logic [16:0] p_stride;
  longint      p_bins [SIDE*SIDE];
  longint      p_max;

  bin_req_t pending_reqs[$];
  bin_res_t expected_results[$];
  bin_req_t drv_q;
  int  offered = 0, accepted = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  adds = 0, reads = 0, clears = 0, drops = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  bit  no_idle = 1'b0;

  function automatic void refresh_stride();
    if (p_maxw != 0) p_stride = 17'd1 + 17'(p_cols / p_maxw);
    else if (p_stride_set == 0) p_stride = 17'd1;
    else p_stride = {1'b0, p_stride_set};
  endfunction

  function automatic int side_of(logic [15:0] extent);
    int g;
    g = int'(extent) / int'(p_stride) + 1;
    return (g > SIDE) ? SIDE : g;
  endfunction

  function automatic logic [6:0] alpha_char(int c);
    if (c < 10) return 7'(48 + c);
    if (c < 36) return 7'(55 + c);
    if (c < 62) return 7'(61 + c);
    return (c == 62) ? 7'd43 : 7'd47;
  endfunction

  function automatic int shade_of(longint x);
    longint mag, acc;
    int t, i;
    if (x == 0) return 0;
    if (p_struct) return (x > 0) ? NTONES : 2 * NTONES;
    mag = (x < 0) ? -x : x;
    if (p_max <= 0 || mag >= p_max) t = NTONES - NTHRES;
    else begin
      acc = 0;
      t = 0;
      for (i = 0; i < NTHRES; i++) begin
        acc += mag;
        if (acc >= p_max) begin
          acc -= p_max;
          t++;
        end
      end
    end
    if (x > 0) return (1 + NTHRES + t > NTONES) ? NTONES : 1 + NTHRES + t;
    return (1 + NTONES + NTHRES + t > 2 * NTONES) ? 2 * NTONES : 1 + NTONES + NTHRES + t;
  endfunction

  function automatic bin_res_t predict_bin(bin_req_t q);
    bin_res_t r;
    int gw, gh, br, bc, k, code;
    longint v, hi, lo, s;
    gw = side_of(p_cols);
    gh = side_of(p_rows);
    code = 0;
    r.status = 1'b0;
    hi = (longint'(1) << (SUMW - 1)) - 1;
    lo = -hi - 1;
    case (mode_t'(q.mode))
      MODE_ADD: begin
        br = int'(q.row) / int'(p_stride);
        bc = int'(q.col) / int'(p_stride);
        if (br >= gh || bc >= gw) r.status = 1'b1;
        else begin
          k = br * SIDE + bc;
          v = longint'($signed(q.value));
          s = p_bins[k];
          if (v > 0 && s > hi - v) s = hi;
          else if (v < 0 && s < lo - v) s = lo;
          else s = s + v;
          p_bins[k] = s;
          if (s > p_max) p_max = s;
        end
      end
      MODE_READ: begin
        if (q.row >= gh || q.col >= gw) r.status = 1'b1;
        else code = shade_of(p_bins[int'(q.row) * SIDE + int'(q.col)]);
      end
      MODE_CLEAR: begin
        foreach (p_bins[i]) p_bins[i] = 0;
        p_max = 0;
      end
      default: ;
    endcase
    r.code = 6'(code);
    r.chr = alpha_char(code);
    r.gw = 7'(gw);
    r.gh = 7'(gh);
    return r;
  endfunction

  // Driver: offers queued transactions, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && accepted != offered) begin
      // Hold the offered transaction until it is taken.
    end else if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
      drv_q = pending_reqs.pop_front();
      offered++;
      in_ch.valid       <= 1'b1;
      in_ch.mode        <= drv_q.mode;
      in_ch.row_index   <= drv_q.row;
      in_ch.col_index   <= drv_q.col;
      in_ch.entry_value <= drv_q.value;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Acceptance: predict on the edge the transaction is taken.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      bin_req_t q;
      q = '{in_ch.mode, in_ch.row_index, in_ch.col_index, in_ch.entry_value};
      accepted++;
      expected_results.push_back(predict_bin(q));
      case (mode_t'(q.mode))
        MODE_ADD: adds++;
        MODE_READ: reads++;
        MODE_CLEAR: clears++;
        default: ;
      endcase
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 30);
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bin_res_t got, want;
      got = '{out_ch.palette_index, out_ch.pixel_char, out_ch.status,
              out_ch.grid_width, out_ch.grid_height};
      results_seen++;
      if (got.status) drops++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p, got %p", results_seen, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL sparse_matrix_density_binner_top");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 ||
           accepted != offered) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ROWS:   p_rows = d;
      REG_COLS:   p_cols = d;
      REG_MAXW:   p_maxw = d[5:0];
      REG_STRIDE: p_stride_set = d;
      REG_STRUCT: p_struct = d[0];
      default: ;
    endcase
    refresh_stride();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic setup(logic [15:0] r, logic [15:0] c, logic [5:0] mw,
                       logic [15:0] st, logic so);
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    write_reg(REG_MAXW, {10'd0, mw});
    write_reg(REG_STRIDE, st);
    write_reg(REG_STRUCT, {15'd0, so});
  endtask

  function automatic void push(logic [1:0] m, logic [15:0] r, logic [15:0] c,
                               logic [31:0] v);
    bin_req_t q;
    q = '{m, r, c, v};
    pending_reqs.push_back(q);
  endfunction

  // Random value: full range, small magnitudes, or near the extremes.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(15)
                                  : 32'h8000_0000 + $urandom_range(15);
      default: return 32'($urandom_range(65535));
    endcase
  endfunction

  // Mostly in-grid adds and reads; some clears, no-ops and out-of-grid noise.
  task automatic random_phase(int n);
    int i, gw, gh, sel;
    logic [15:0] r, c;
    gw = side_of(p_cols);
    gh = side_of(p_rows);
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 2) push(MODE_CLEAR, 16'($urandom()), 16'($urandom()), $urandom());
      else if (sel < 4) push(MODE_NOP, 16'($urandom()), 16'($urandom()), $urandom());
      else if (sel < 50) begin
        if ($urandom_range(9) == 0) begin
          r = 16'($urandom());
          c = 16'($urandom());
        end else begin
          r = 16'($urandom_range(gh * int'(p_stride) - 1 > 65535 ? 65535
                                 : gh * int'(p_stride) - 1));
          c = 16'($urandom_range(gw * int'(p_stride) - 1 > 65535 ? 65535
                                 : gw * int'(p_stride) - 1));
        end
        push(MODE_ADD, r, c, rand_value());
      end else begin
        if ($urandom_range(9) == 0) begin
          r = 16'($urandom());
          c = 16'($urandom());
        end else begin
          r = 16'($urandom_range(gh));
          c = 16'($urandom_range(gw));
        end
        push(MODE_READ, r, c, $urandom());
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NOP;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.entry_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROWS;
    cfg_ch.data = '0;
    p_rows = 16'd1;
    p_cols = 16'd1;
    p_maxw = '0;
    p_stride_set = 16'd1;
    p_struct = 1'b0;
    p_max = 0;
    foreach (p_bins[i]) p_bins[i] = 0;
    refresh_stride();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, extremes on a wide grid, then structure mode.
    push(MODE_ADD, 16'd0, 16'd0, 32'h0001_0000);
    push(MODE_ADD, 16'd2, 16'd0, 32'h0001_0000);
    push(MODE_READ, 16'd0, 16'd0, '0);
    push(MODE_READ, 16'd0, 16'd2, '0);
    push(MODE_NOP, 16'hffff, 16'hffff, 32'hffff_ffff);
    wait_drained();
    setup(16'hffff, 16'hffff, 6'd0, 16'd1, 1'b0);
    push(MODE_ADD, 16'd63, 16'd63, 32'h7fff_ffff);
    push(MODE_ADD, 16'd64, 16'd0, 32'h7fff_ffff);
    push(MODE_ADD, 16'd1, 16'd1, 32'h8000_0000);
    push(MODE_ADD, 16'd2, 16'd2, 32'h0000_0001);
    repeat (3) push(MODE_ADD, 16'd3, 16'd3, 32'h7fff_ffff);
    push(MODE_READ, 16'd63, 16'd63, '0);
    push(MODE_READ, 16'd1, 16'd1, '0);
    push(MODE_READ, 16'd2, 16'd2, '0);
    push(MODE_READ, 16'd3, 16'd3, '0);
    push(MODE_READ, 16'd5, 16'd5, '0);
    push(MODE_READ, 16'd64, 16'd0, '0);
    push(MODE_READ, 16'hffff, 16'hffff, '0);
    push(MODE_CLEAR, 16'd0, 16'd0, '0);
    push(MODE_READ, 16'd63, 16'd63, '0);
    wait_drained();
    setup(16'hffff, 16'hffff, 6'd1, 16'd0, 1'b1);
    push(MODE_ADD, 16'hffff, 16'hffff, 32'hffff_0000);
    push(MODE_ADD, 16'd5, 16'd5, 32'h0000_0100);
    push(MODE_READ, 16'd0, 16'd0, '0);
    push(MODE_READ, 16'd0, 16'd1, '0);
    wait_drained();

    // Random phases over several settings, extremes included.
    setup(16'd200, 16'd300, 6'd0, 16'd7, 1'b0);
    no_idle = 1'b1;
    random_phase(250);
    wait_drained();
    no_idle = 1'b0;
    setup(16'd40, 16'd40, 6'd0, 16'd0, 1'b0);
    random_phase(300);
    // Long receiver stall while items keep being offered.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    wait_drained();
    setup(16'd1000, 16'd5000, 6'd63, 16'hffff, 1'b1);
    random_phase(300);
    wait_drained();
    setup(16'hffff, 16'd20, 6'd8, 16'd3, 1'b0);
    random_phase(300);
    wait_drained();
    setup(16'd1, 16'd1, 6'd0, 16'hffff, 1'b0);
    random_phase(150);
    wait_drained();
    setup(16'd500, 16'd500, 6'd0, 16'd9, 1'b0);
    random_phase(300);
    wait_drained();
    setup(16'd100, 16'd100, 6'd32, 16'd1, 1'b1);
    random_phase(250);
    wait_drained();

    $display("Covered %0d adds, %0d reads, %0d clears; %0d results, %0d flagged out of grid.",
             adds, reads, clears, results_seen, drops);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS sparse_matrix_density_binner_top");
    end else begin
      $display("FAIL sparse_matrix_density_binner_top");
    end
    $finish;
  end

endmodule
